FILE: sv/apsp_pkg.sv
// shared types and constants for the all-pairs shortest path engine
package apsp_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int DIST_W           = 24;
   localparam int HOP_W            = 5;
   localparam int VTX_W            = 5;
   localparam int WEIGHT_W         = 16;
   localparam int OP_W             = 2;
   localparam int CFG_W            = 6;

   localparam logic [DIST_W-1:0] NO_EDGE   = 24'd114514;
   localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_RUN   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      logic load_we;
      logic query_rd;
      logic clear_we;
      logic fetch;
      logic latch;
      logic scan;
      logic rsp_send;
      logic rsp_query;
      logic rsp_outside;
   } cmd_type;

endpackage

FILE: sv/all_pairs_shortest_path.sv
// top level of the all-pairs shortest path engine
//
//   channel   direction  handshake              payload
//   request   in         start & !busy          req_opcode, req_source_vertex,
//                                               req_target_vertex, req_edge_weight
//   response  out        rsp_valid, one cycle   rsp_path_distance, rsp_first_hop,
//                                               rsp_no_path, rsp_done_res
//   csr       in         csr_write_en           csr_write_data (vertex count)
//
// load and query are answered with a response in the next cycle, one per cycle
// clear walks the n by n matrix, one matrix entry written per cycle
// run makes one relaxation per cycle through the matrix memory while scanning a row,
// with a fetch state and a latch state before each row to get the (i,k) entry
// reset is synchronous; the matrices hold nothing defined until a clear
// results cannot be stalled; busy holds off requests during clear and run
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [apsp_pkg::OP_W-1:0]           req_opcode,
   input  logic [apsp_pkg::VTX_W-1:0]          req_source_vertex,
   input  logic [apsp_pkg::VTX_W-1:0]          req_target_vertex,
   input  logic [apsp_pkg::WEIGHT_W-1:0]       req_edge_weight,
   output logic                                rsp_valid,
   output logic [apsp_pkg::DIST_W-1:0]         rsp_path_distance,
   output logic [apsp_pkg::HOP_W-1:0]          rsp_first_hop,
   output logic                                rsp_no_path,
   output logic                                rsp_done_res,
   input  logic                                csr_write_en,
   input  logic [apsp_pkg::CFG_W-1:0]          csr_write_data
);

   localparam int VW = $clog2(MAX_VERTICES);

   apsp_pkg::cmd_type cmd;
   logic [VW-1:0]     idx_i, idx_j, idx_k;

   apsp_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_opcode        (req_opcode),
      .req_source_vertex (req_source_vertex),
      .req_target_vertex (req_target_vertex),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .busy              (busy),
      .cmd               (cmd),
      .idx_i             (idx_i),
      .idx_j             (idx_j),
      .idx_k             (idx_k)
   );

   apsp_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .idx_i             (idx_i),
      .idx_j             (idx_j),
      .idx_k             (idx_k),
      .req_edge_weight   (req_edge_weight),
      .rsp_valid         (rsp_valid),
      .rsp_path_distance (rsp_path_distance),
      .rsp_first_hop     (rsp_first_hop),
      .rsp_no_path       (rsp_no_path),
      .rsp_done_res      (rsp_done_res)
   );

`ifndef SYNTHESIS
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   a_short_ops_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == apsp_pkg::OP_LOAD ||
                          req_opcode == apsp_pkg::OP_QUERY)) |=> rsp_valid)
      else $error("load or query not answered in the next cycle");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response issued while clear or run still in progress");

   a_no_path_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_path) |-> (rsp_path_distance >= apsp_pkg::NO_EDGE))
      else $error("no-path flag with a distance below the no-edge value");
`endif

endmodule

FILE: sv/apsp_ctrl.sv
// controller: request decode, loop counters and sequencing of clear and relaxation
module apsp_ctrl #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [apsp_pkg::OP_W-1:0]           req_opcode,
   input  logic [apsp_pkg::VTX_W-1:0]          req_source_vertex,
   input  logic [apsp_pkg::VTX_W-1:0]          req_target_vertex,
   input  logic                                csr_write_en,
   input  logic [apsp_pkg::CFG_W-1:0]          csr_write_data,
   output logic                                busy,
   output apsp_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]     idx_i,
   output logic [$clog2(MAX_VERTICES)-1:0]     idx_j,
   output logic [$clog2(MAX_VERTICES)-1:0]     idx_k
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int EXT_W = (VW > apsp_pkg::VTX_W) ? VW : apsp_pkg::VTX_W;
   localparam logic [6:0] MAX_V7 = 7'(MAX_VERTICES);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CLEAR  = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_LATCH  = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [VW-1:0]                 i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [apsp_pkg::CFG_W-1:0]    vertex_count_ff, vertex_count_in;

   logic [6:0]                    cnt7, n7;
   logic [CNT_W-1:0]              n, n_m1;
   logic                          n_zero, i_last, j_last, k_last;
   logic [EXT_W-1:0]              src_ext, tgt_ext;
   logic                          in_range;
   apsp_pkg::op_type              op;

   always_comb begin
      vertex_count_in = csr_write_en ? csr_write_data : vertex_count_ff;
   end

   always_comb begin
      cnt7     = {1'b0, vertex_count_ff};
      n7       = (cnt7 > MAX_V7) ? MAX_V7 : cnt7;
      n        = n7[CNT_W-1:0];
      n_m1     = n - CNT_W'(1);
      n_zero   = (n == '0);
      i_last   = (CNT_W'(i_ff) == n_m1);
      j_last   = (CNT_W'(j_ff) == n_m1);
      k_last   = (CNT_W'(k_ff) == n_m1);
      src_ext  = EXT_W'(req_source_vertex);
      tgt_ext  = EXT_W'(req_target_vertex);
      in_range = ({2'b00, req_source_vertex} < MAX_V7) &&
                 ({2'b00, req_target_vertex} < MAX_V7);
      op       = apsp_pkg::op_type'(req_opcode);
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      idx_i    = i_ff;
      idx_j    = j_ff;
      idx_k    = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_i = src_ext[VW-1:0];
            idx_j = tgt_ext[VW-1:0];
            if (start) begin
               unique case (op)
                  apsp_pkg::OP_CLEAR: begin
                     i_in = '0;
                     j_in = '0;
                     if (n_zero) begin
                        cmd.rsp_send = 1'b1;
                     end else begin
                        state_in = ST_CLEAR;
                     end
                  end
                  apsp_pkg::OP_LOAD: begin
                     cmd.load_we  = in_range;
                     cmd.rsp_send = 1'b1;
                  end
                  apsp_pkg::OP_RUN: begin
                     i_in = '0;
                     j_in = '0;
                     k_in = '0;
                     if (n_zero) begin
                        cmd.rsp_send = 1'b1;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  apsp_pkg::OP_QUERY: begin
                     cmd.rsp_send    = 1'b1;
                     cmd.query_rd    = in_range;
                     cmd.rsp_query   = in_range;
                     cmd.rsp_outside = !in_range;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  cmd.rsp_send = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  i_in = i_ff + VW'(1);
               end
            end else begin
               j_in = j_ff + VW'(1);
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            j_in      = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  i_in = '0;
                  if (k_last) begin
                     state_in = ST_FINISH;
                  end else begin
                     k_in     = k_ff + VW'(1);
                     state_in = ST_FETCH;
                  end
               end else begin
                  i_in     = i_ff + VW'(1);
                  state_in = ST_FETCH;
               end
            end else begin
               j_in = j_ff + VW'(1);
            end
         end
         ST_FINISH: begin
            cmd.rsp_send = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         i_ff            <= '0;
         j_ff            <= '0;
         k_ff            <= '0;
         vertex_count_ff <= apsp_pkg::CFG_RESET;
      end else begin
         state_ff        <= state_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         k_ff            <= k_in;
         vertex_count_ff <= vertex_count_in;
      end
   end

endmodule

FILE: sv/apsp_dpath.sv
// datapath: distance and next-hop memories, relaxation compare and response registers
module apsp_dpath #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  apsp_pkg::cmd_type                   cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]     idx_i,
   input  logic [$clog2(MAX_VERTICES)-1:0]     idx_j,
   input  logic [$clog2(MAX_VERTICES)-1:0]     idx_k,
   input  logic [apsp_pkg::WEIGHT_W-1:0]       req_edge_weight,
   output logic                                rsp_valid,
   output logic [apsp_pkg::DIST_W-1:0]         rsp_path_distance,
   output logic [apsp_pkg::HOP_W-1:0]          rsp_first_hop,
   output logic                                rsp_no_path,
   output logic                                rsp_done_res
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int AW    = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam int EXT_W = (VW > apsp_pkg::HOP_W) ? VW : apsp_pkg::HOP_W;
   localparam int DW    = apsp_pkg::DIST_W;
   localparam int HW    = apsp_pkg::HOP_W;

   logic [DW-1:0]    dist_mem [DEPTH];
   logic [HW-1:0]    hop_mem  [DEPTH];

   logic [AW-1:0]    addr_a, addr_b, waddr;
   logic             rd_en, we, hop_we;
   logic [DW-1:0]    wdist;
   logic [HW-1:0]    whop;
   logic [EXT_W-1:0] j_ext;

   logic [DW-1:0]    rd_a_dist_ff, rd_b_dist_ff;
   logic [HW-1:0]    rd_a_hop_ff;
   logic [DW-1:0]    dik_ff;
   logic [HW-1:0]    nik_ff;
   logic             scan_d1_ff;
   logic [VW-1:0]    i_d1_ff, j_d1_ff;
   logic [DW:0]      via;
   logic             relax_we;

   logic             rsp_valid_ff, rsp_query_ff, rsp_outside_ff;

   always_comb begin
      addr_a   = cmd.fetch ? {idx_i, idx_k} : {idx_i, idx_j};
      addr_b   = {idx_k, idx_j};
      rd_en    = cmd.query_rd || cmd.fetch || cmd.scan;
      via      = {1'b0, dik_ff} + {1'b0, rd_b_dist_ff};
      relax_we = scan_d1_ff && (via < {1'b0, rd_a_dist_ff});
      j_ext    = EXT_W'(idx_j);
   end

   // write port: relaxation, clear and load never overlap
   always_comb begin
      we     = 1'b0;
      hop_we = 1'b0;
      waddr  = {idx_i, idx_j};
      wdist  = DW'(req_edge_weight);
      whop   = nik_ff;
      priority if (relax_we) begin
         we     = 1'b1;
         hop_we = 1'b1;
         waddr  = {i_d1_ff, j_d1_ff};
         wdist  = via[DW-1:0];
      end else if (cmd.clear_we) begin
         we     = 1'b1;
         hop_we = 1'b1;
         wdist  = (idx_i == idx_j) ? '0 : apsp_pkg::NO_EDGE;
         whop   = j_ext[HW-1:0];
      end else if (cmd.load_we) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         dist_mem[waddr] <= wdist;
      end
      if (we && hop_we) begin
         hop_mem[waddr] <= whop;
      end
      if (rd_en) begin
         rd_a_dist_ff <= dist_mem[addr_a];
         rd_a_hop_ff  <= hop_mem[addr_a];
         rd_b_dist_ff <= dist_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         dik_ff <= rd_a_dist_ff;
         nik_ff <= rd_a_hop_ff;
      end
      i_d1_ff <= idx_i;
      j_d1_ff <= idx_j;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_d1_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_query_ff   <= 1'b0;
         rsp_outside_ff <= 1'b0;
      end else begin
         scan_d1_ff     <= cmd.scan;
         rsp_valid_ff   <= cmd.rsp_send;
         rsp_query_ff   <= cmd.rsp_query;
         rsp_outside_ff <= cmd.rsp_outside;
      end
   end

   always_comb begin
      rsp_valid    = rsp_valid_ff;
      rsp_done_res = rsp_valid_ff;
      if (rsp_query_ff) begin
         rsp_path_distance = rd_a_dist_ff;
         rsp_first_hop     = rd_a_hop_ff;
         rsp_no_path       = (rd_a_dist_ff >= apsp_pkg::NO_EDGE);
      end else begin
         rsp_path_distance = rsp_outside_ff ? apsp_pkg::NO_EDGE : '0;
         rsp_first_hop     = '0;
         rsp_no_path       = rsp_outside_ff;
      end
   end

endmodule

FILE: test/tb_all_pairs_shortest_path.sv
// self-checking testbench for the all-pairs shortest path engine
`timescale 1ns / 100ps

module tb_all_pairs_shortest_path;

   localparam int M = apsp_pkg::MAX_VERTICES_DEF;
   localparam int RANDOM_REQUESTS = 1750;

   typedef struct {
      logic [apsp_pkg::DIST_W-1:0] distance;
      logic [apsp_pkg::HOP_W-1:0]  hop;
      logic                        no_path;
      logic                        done;
   } answer_type;

   class shortest_paths;
      logic [apsp_pkg::DIST_W-1:0] distance [M*M];
      logic [apsp_pkg::HOP_W-1:0]  hop [M*M];
      logic [apsp_pkg::CFG_W-1:0]  vertex_count;
      answer_type                  awaited_answers [$];
      int                          mismatches;

      function new();
         vertex_count = apsp_pkg::CFG_RESET;
         mismatches = 0;
         foreach (distance[i]) begin
            distance[i] = '0;
            hop[i] = '0;
         end
      endfunction

      function int active_vertices();
         return (vertex_count > M) ? M : int'(vertex_count);
      endfunction

      function void set_vertex_count(logic [apsp_pkg::CFG_W-1:0] value);
         vertex_count = value;
      endfunction

      function int pending();
         return awaited_answers.size();
      endfunction

      function void take_request(apsp_pkg::op_type op, logic [apsp_pkg::VTX_W-1:0] src,
                                 logic [apsp_pkg::VTX_W-1:0] dst,
                                 logic [apsp_pkg::WEIGHT_W-1:0] weight);
         answer_type                a;
         int                        n;
         int                        i;
         int                        j;
         int                        k;
         logic [apsp_pkg::DIST_W:0] via;
         a.distance = '0;
         a.hop = '0;
         a.no_path = 1'b0;
         a.done = 1'b1;
         n = active_vertices();
         case (op)
            apsp_pkg::OP_CLEAR: begin
               for (i = 0; i < n; i++)
                  for (j = 0; j < n; j++) begin
                     distance[i*M+j] = (i == j) ? '0 : apsp_pkg::NO_EDGE;
                     hop[i*M+j] = apsp_pkg::HOP_W'(j);
                  end
            end
            apsp_pkg::OP_LOAD: begin
               if (int'(src) < M && int'(dst) < M)
                  distance[src*M+dst] = apsp_pkg::DIST_W'(weight);
            end
            apsp_pkg::OP_RUN: begin
               for (k = 0; k < n; k++)
                  for (i = 0; i < n; i++)
                     for (j = 0; j < n; j++) begin
                        via = {1'b0, distance[i*M+k]} + {1'b0, distance[k*M+j]};
                        if (via < {1'b0, distance[i*M+j]}) begin
                           distance[i*M+j] = via[apsp_pkg::DIST_W-1:0];
                           hop[i*M+j] = hop[i*M+k];
                        end
                     end
            end
            default: begin
               if (int'(src) < M && int'(dst) < M) begin
                  a.distance = distance[src*M+dst];
                  a.hop = hop[src*M+dst];
                  a.no_path = (a.distance >= apsp_pkg::NO_EDGE);
               end else begin
                  a.distance = apsp_pkg::NO_EDGE;
                  a.no_path = 1'b1;
               end
            end
         endcase
         awaited_answers.push_back(a);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (awaited_answers.size() == 0) begin
            $error("response with no request waiting");
            mismatches++;
            return;
         end
         want = awaited_answers.pop_front();
         if (got.distance !== want.distance) begin
            $error("path_distance: expected %0d, got %0d", want.distance, got.distance);
            mismatches++;
         end
         if (got.hop !== want.hop) begin
            $error("first_hop: expected %0d, got %0d", want.hop, got.hop);
            mismatches++;
         end
         if (got.no_path !== want.no_path) begin
            $error("no_path: expected %0b, got %0b", want.no_path, got.no_path);
            mismatches++;
         end
         if (got.done !== want.done) begin
            $error("done_res: expected %0b, got %0b", want.done, got.done);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [apsp_pkg::OP_W-1:0]     req_opcode = '0;
   logic [apsp_pkg::VTX_W-1:0]    req_source_vertex = '0;
   logic [apsp_pkg::VTX_W-1:0]    req_target_vertex = '0;
   logic [apsp_pkg::WEIGHT_W-1:0] req_edge_weight = '0;
   logic                          rsp_valid;
   logic [apsp_pkg::DIST_W-1:0]   rsp_path_distance;
   logic [apsp_pkg::HOP_W-1:0]    rsp_first_hop;
   logic                          rsp_no_path;
   logic                          rsp_done_res;
   logic                          csr_write_en = 1'b0;
   logic [apsp_pkg::CFG_W-1:0]    csr_write_data = '0;

   shortest_paths paths = new();

   bit idle_on = 1'b1;
   int runs_left;
   int clears_left;
   int requests_sent = 0;
   int query_count = 0;
   int run_count = 0;
   int clear_count = 0;
   int settings_count = 0;

   all_pairs_shortest_path dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_source_vertex (req_source_vertex),
      .req_target_vertex (req_target_vertex),
      .req_edge_weight   (req_edge_weight),
      .rsp_valid         (rsp_valid),
      .rsp_path_distance (rsp_path_distance),
      .rsp_first_hop     (rsp_first_hop),
      .rsp_no_path       (rsp_no_path),
      .rsp_done_res      (rsp_done_res),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         paths.check_answer(answer_type'{distance: rsp_path_distance, hop: rsp_first_hop,
                                         no_path: rsp_no_path, done: rsp_done_res});
   end

   function automatic logic [apsp_pkg::VTX_W-1:0] pick_vertex(int n);
      return (n == 0) ? apsp_pkg::VTX_W'($urandom_range(0, M - 1))
                      : apsp_pkg::VTX_W'($urandom_range(0, n - 1));
   endfunction

   function automatic logic [apsp_pkg::WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return apsp_pkg::WEIGHT_W'($urandom_range(0, 65535));
         default: return apsp_pkg::WEIGHT_W'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic send_request(apsp_pkg::op_type op, logic [apsp_pkg::VTX_W-1:0] src,
                               logic [apsp_pkg::VTX_W-1:0] dst,
                               logic [apsp_pkg::WEIGHT_W-1:0] weight);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_source_vertex <= src;
      req_target_vertex <= dst;
      req_edge_weight <= weight;
      do @(posedge clock); while (busy);
      paths.take_request(op, src, dst, weight);
      requests_sent++;
      case (op)
         apsp_pkg::OP_QUERY: query_count++;
         apsp_pkg::OP_RUN:   run_count++;
         apsp_pkg::OP_CLEAR: clear_count++;
         default:            ;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (paths.pending() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [apsp_pkg::CFG_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      paths.set_vertex_count(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_count++;
   endtask

   task automatic graph_sequence();
      int n;
      int loads;
      int queries;
      n = paths.active_vertices();
      loads = $urandom_range(0, 2 * n + 1);
      queries = $urandom_range(1, n + 2);
      if (clears_left > 0) begin
         clears_left--;
         send_request(apsp_pkg::OP_CLEAR, pick_vertex(n), pick_vertex(n), pick_weight());
      end
      repeat (loads)
         send_request(apsp_pkg::OP_LOAD, pick_vertex(n), pick_vertex(n), pick_weight());
      if (runs_left > 0) begin
         runs_left--;
         send_request(apsp_pkg::OP_RUN, pick_vertex(n), pick_vertex(n), pick_weight());
      end
      repeat (queries)
         send_request(apsp_pkg::OP_QUERY, pick_vertex(n), pick_vertex(n), pick_weight());
   endtask

   task automatic noise_burst();
      int pick;
      apsp_pkg::op_type op;
      repeat ($urandom_range(1, 5)) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            op = apsp_pkg::OP_LOAD;
         else if (pick < 9)
            op = apsp_pkg::OP_QUERY;
         else if ($urandom_range(0, 1) == 1 && clears_left > 0) begin
            op = apsp_pkg::OP_CLEAR;
            clears_left--;
         end else if (runs_left > 0) begin
            op = apsp_pkg::OP_RUN;
            runs_left--;
         end else
            op = apsp_pkg::OP_QUERY;
         send_request(op, apsp_pkg::VTX_W'($urandom_range(0, 31)),
                      apsp_pkg::VTX_W'($urandom_range(0, 31)),
                      apsp_pkg::WEIGHT_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      int goal;
      int phase_end;
      int pick;
      int n;
      int big_phases;
      logic [apsp_pkg::CFG_W-1:0] count;
      big_phases = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // full-size graph at the reset vertex count
      send_request(apsp_pkg::OP_CLEAR, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd31, 5'd30, 16'd0);
      send_request(apsp_pkg::OP_LOAD, 5'd0, 5'd1, 16'h0000);
      send_request(apsp_pkg::OP_LOAD, 5'd1, 5'd31, 16'hFFFF);
      send_request(apsp_pkg::OP_LOAD, 5'd31, 5'd0, 16'h0001);
      send_request(apsp_pkg::OP_QUERY, 5'd0, 5'd1, 16'd0);
      send_request(apsp_pkg::OP_RUN, 5'd31, 5'd31, 16'hFFFF);
      send_request(apsp_pkg::OP_QUERY, 5'd0, 5'd31, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd31, 5'd1, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd1, 5'd0, 16'd0);

      // single vertex, entries beyond the count stay as they were
      write_vertex_count(6'd1);
      send_request(apsp_pkg::OP_LOAD, 5'd0, 5'd0, 16'd5);
      send_request(apsp_pkg::OP_CLEAR, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_RUN, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd5, 5'd9, 16'd0);

      // zero count, clear and run leave the matrices alone
      write_vertex_count(6'd0);
      send_request(apsp_pkg::OP_CLEAR, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_RUN, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd1, 5'd0, 16'd0);

      // count above the storage saturates, load keeps the old next hop
      write_vertex_count(6'd63);
      send_request(apsp_pkg::OP_LOAD, 5'd1, 5'd0, 16'd2);
      send_request(apsp_pkg::OP_QUERY, 5'd1, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_LOAD, 5'd2, 5'd3, 16'd7);
      send_request(apsp_pkg::OP_RUN, 5'd0, 5'd0, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd2, 5'd3, 16'd0);
      send_request(apsp_pkg::OP_QUERY, 5'd31, 5'd31, 16'd0);

      goal = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 4 && big_phases < 2) begin
            big_phases++;
            count = ($urandom_range(0, 1) == 1) ? 6'd32
                                                : apsp_pkg::CFG_W'($urandom_range(33, 63));
         end else if (pick < 8)
            count = 6'd0;
         else if (pick < 22)
            count = apsp_pkg::CFG_W'($urandom_range(9, 16));
         else
            count = apsp_pkg::CFG_W'($urandom_range(1, 8));
         write_vertex_count(count);
         n = paths.active_vertices();
         runs_left = (n > 16) ? 1 : (n > 8) ? 3 : 6;
         clears_left = 2 * runs_left;
         idle_on = ($urandom_range(0, 3) != 0);
         phase_end = requests_sent + $urandom_range(30, 70);
         while (requests_sent < phase_end && requests_sent < goal) begin
            if ($urandom_range(0, 4) != 0)
               graph_sequence();
            else
               noise_burst();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: %0d queries, %0d relaxation runs, %0d clears",
               requests_sent, query_count, run_count, clear_count);
      $display("vertex count rewritten %0d times, covering 0, 1, saturating and random values",
               settings_count);
      if (paths.mismatches == 0 && paths.pending() == 0)
         $display("[all_pairs_shortest_path] OK");
      else
         $display("[all_pairs_shortest_path] ERROR");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout waiting for the engine");
      $display("[all_pairs_shortest_path] ERROR");
      $finish;
   end

endmodule

FILE: files.f
sv/apsp_pkg.sv
sv/apsp_ctrl.sv
sv/apsp_dpath.sv
sv/all_pairs_shortest_path.sv
test/tb_all_pairs_shortest_path.sv
